// File: src/itd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itd_pkg
// Shared constants, types and helpers for the incremental tree diameter block.
// ----------------------------------------------------------------------------
package itd_pkg;

  localparam int MAX_NODES = 65536;
  localparam int LEVELS    = 16;

  localparam int NODE_W    = $clog2(MAX_NODES + 1);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int DEP_W     = NODE_W;
  localparam int DIST_W    = DEP_W + 1;
  localparam int CMP_W     = ((DEP_W > LEVELS) ? DEP_W : LEVELS) + 1;
  localparam int DIAM_W    = 16;
  localparam int ST_W      = 2;
  localparam int DEP_DEPTH = MAX_NODES + 1;
  localparam int ANC_DEPTH = 1 << (NODE_W + LVL_W);

  localparam logic [NODE_W-1:0] ROOT_NODE  = NODE_W'(1);
  localparam logic [NODE_W-1:0] LAST_FIXED = NODE_W'(4);
  localparam logic [NODE_W-1:0] RESET_A    = NODE_W'(2);
  localparam logic [NODE_W-1:0] RESET_B    = NODE_W'(3);
  localparam logic [NODE_W-1:0] RESET_CNT  = NODE_W'(4);
  localparam logic [LVL_W-1:0]  LVL_TOP    = LVL_W'(LEVELS - 1);

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_XDEP, S_WDEP2, S_W0B, S_FSEL, S_FRD1, S_FRD2, S_FWA, S_FWB,
    S_LSTART, S_LIFT, S_LIFTW, S_EQ, S_CLB, S_CLP, S_CLQ, S_FIN0, S_FIN1,
    S_MDEP, S_SWAP, S_DONE
  } state_t;

  typedef struct packed {
    logic              rd;
    logic [NODE_W-1:0] rd_node;
    logic [LVL_W-1:0]  rd_lvl;
    logic              wr;
    logic [NODE_W-1:0] wr_node;
    logic [LVL_W-1:0]  wr_lvl;
    logic [NODE_W-1:0] wr_data;
  } anc_req_t;

  typedef struct packed {
    logic              rd;
    logic [NODE_W-1:0] rd_node;
    logic              wr;
    logic [NODE_W-1:0] wr_node;
    logic [DEP_W-1:0]  wr_data;
  } dep_req_t;

  function automatic logic [CMP_W-1:0] step_of(input logic [LVL_W-1:0] lvl);
    return CMP_W'(1) << lvl;
  endfunction

endpackage
`default_nettype wire

// File: src/itd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itd_if
// Valid/ready channels for the input item and the result item.
// ----------------------------------------------------------------------------
interface itd_in_if;
  logic                      valid;
  logic                      ready;
  logic [itd_pkg::NODE_W-1:0] attach_node;
  modport source (output valid, output attach_node, input ready);
  modport sink   (input valid, input attach_node, output ready);
endinterface

interface itd_out_if;
  logic                       valid;
  logic                       ready;
  logic [itd_pkg::DIAM_W-1:0] diameter;
  logic [itd_pkg::ST_W-1:0]   status;
  modport source (output valid, output diameter, output status, input ready);
  modport sink   (input valid, input diameter, input status, output ready);
endinterface
`default_nettype wire

// File: src/itd_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itd_store
// Depth memory and binary-lifting ancestor memory, one read and one write
// port each, registered read data. The fixed nodes of the initial tree are
// answered from logic, so neither memory needs clearing.
// ----------------------------------------------------------------------------
module itd_store (
  input  wire logic                      clk,
  input  wire itd_pkg::anc_req_t         anc_req,
  input  wire itd_pkg::dep_req_t         dep_req,
  output logic [itd_pkg::NODE_W-1:0]     anc_q,
  output logic [itd_pkg::DEP_W-1:0]      dep_q
);

  logic [itd_pkg::NODE_W-1:0] anc_mem [itd_pkg::ANC_DEPTH];
  logic [itd_pkg::DEP_W-1:0]  dep_mem [itd_pkg::DEP_DEPTH];

  logic [itd_pkg::NODE_W-1:0] anc_data_r;
  logic                       anc_fixed_r;
  logic [itd_pkg::DEP_W-1:0]  dep_data_r;
  logic                       dep_fixed_r;
  logic                       dep_root_r;

  always_ff @(posedge clk) begin
    if (anc_req.wr) begin
      anc_mem[{anc_req.wr_node, anc_req.wr_lvl}] <= anc_req.wr_data;
    end
    if (anc_req.rd) begin
      anc_data_r  <= anc_mem[{anc_req.rd_node, anc_req.rd_lvl}];
      anc_fixed_r <= (anc_req.rd_node <= itd_pkg::LAST_FIXED);
    end
  end

  always_ff @(posedge clk) begin
    if (dep_req.wr) begin
      dep_mem[dep_req.wr_node] <= dep_req.wr_data;
    end
    if (dep_req.rd) begin
      dep_data_r  <= dep_mem[dep_req.rd_node];
      dep_fixed_r <= (dep_req.rd_node <= itd_pkg::LAST_FIXED);
      dep_root_r  <= (dep_req.rd_node == itd_pkg::ROOT_NODE);
    end
  end

  assign anc_q = anc_fixed_r ? itd_pkg::ROOT_NODE : anc_data_r;
  assign dep_q = dep_fixed_r ? (dep_root_r ? '0 : itd_pkg::DEP_W'(1)) : dep_data_r;

endmodule
`default_nettype wire

// File: src/itd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itd_ctrl
// Sequencer: checks the item, writes the two leaves, fills their ancestor
// rows, runs up to two lowest-common-ancestor walks and updates the endpoints.
// ----------------------------------------------------------------------------
module itd_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [itd_pkg::NODE_W-1:0] in_attach_node,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [itd_pkg::DIAM_W-1:0]     out_diameter,
  output logic [itd_pkg::ST_W-1:0]       out_status,
  output itd_pkg::anc_req_t              anc_req,
  output itd_pkg::dep_req_t              dep_req,
  input  wire logic [itd_pkg::NODE_W-1:0] anc_q,
  input  wire logic [itd_pkg::DEP_W-1:0]  dep_q
);

  itd_pkg::state_t state_r, state_nxt;

  logic [itd_pkg::NODE_W-1:0] x_r, cnt_r, end_a_r, end_b_r, p_r, q_r, up_p_r, a_r;
  logic [itd_pkg::DEP_W-1:0]  d_r, dep_a_r, dep_b_r, de_r, dcur_r, diff_r;
  logic [itd_pkg::DIST_W-1:0] diam_r;
  logic [itd_pkg::LVL_W-1:0]  lvl_r;
  logic                       pass_r;
  itd_pkg::status_t           status_r;
  logic                       out_valid_r;
  logic [itd_pkg::DIAM_W-1:0] out_diameter_r;
  logic [itd_pkg::ST_W-1:0]   out_status_r;

  logic [itd_pkg::NODE_W-1:0]   n1, n2, e_sel;
  logic [itd_pkg::DEP_W-1:0]    de_sel;
  logic [itd_pkg::CMP_W-1:0]    step;
  logic [itd_pkg::DIST_W-1:0]   path_len;
  logic [itd_pkg::DIST_W+itd_pkg::DIAM_W-1:0] diam_ext;
  logic                         fill_go, lift_go, climb_go, lvl_zero, at_top, absent, full;

  assign n1       = cnt_r + itd_pkg::NODE_W'(1);
  assign n2       = cnt_r + itd_pkg::NODE_W'(2);
  assign step     = itd_pkg::step_of(lvl_r);
  assign fill_go  = step <= itd_pkg::CMP_W'(d_r);
  assign lift_go  = itd_pkg::CMP_W'(diff_r) >= step;
  assign climb_go = itd_pkg::CMP_W'(dcur_r) >= step;
  assign lvl_zero = (lvl_r == '0);
  assign at_top   = (lvl_r == itd_pkg::LVL_TOP);
  assign e_sel    = pass_r ? end_b_r : end_a_r;
  assign de_sel   = pass_r ? dep_b_r : dep_a_r;
  assign path_len = itd_pkg::DIST_W'(de_r) + itd_pkg::DIST_W'(d_r) - {dep_q, 1'b0};
  assign diam_ext = (itd_pkg::DIST_W + itd_pkg::DIAM_W)'(diam_r);
  assign absent   = (in_attach_node == '0) || (in_attach_node > cnt_r);
  assign full     = ((itd_pkg::NODE_W + 1)'(cnt_r) + (itd_pkg::NODE_W + 1)'(2)) >
                    (itd_pkg::NODE_W + 1)'(itd_pkg::MAX_NODES);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itd_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (absent || full) ? itd_pkg::S_DONE : itd_pkg::S_XDEP;
        end
      end
      itd_pkg::S_XDEP:   state_nxt = itd_pkg::S_WDEP2;
      itd_pkg::S_WDEP2:  state_nxt = itd_pkg::S_W0B;
      itd_pkg::S_W0B:    state_nxt = itd_pkg::S_FSEL;
      itd_pkg::S_FSEL:   state_nxt = fill_go ? itd_pkg::S_FRD1 : itd_pkg::S_FWA;
      itd_pkg::S_FRD1:   state_nxt = itd_pkg::S_FRD2;
      itd_pkg::S_FRD2:   state_nxt = itd_pkg::S_FWA;
      itd_pkg::S_FWA:    state_nxt = itd_pkg::S_FWB;
      itd_pkg::S_FWB:    state_nxt = at_top ? itd_pkg::S_LSTART : itd_pkg::S_FSEL;
      itd_pkg::S_LSTART: state_nxt = itd_pkg::S_LIFT;
      itd_pkg::S_LIFT: begin
        if (lift_go) begin
          state_nxt = itd_pkg::S_LIFTW;
        end else if (lvl_zero) begin
          state_nxt = itd_pkg::S_EQ;
        end
      end
      itd_pkg::S_LIFTW:  state_nxt = itd_pkg::S_LIFT;
      itd_pkg::S_EQ:     state_nxt = (p_r == q_r) ? itd_pkg::S_MDEP : itd_pkg::S_CLB;
      itd_pkg::S_CLB: begin
        if (climb_go) begin
          state_nxt = itd_pkg::S_CLP;
        end else if (lvl_zero) begin
          state_nxt = itd_pkg::S_FIN0;
        end
      end
      itd_pkg::S_CLP:    state_nxt = itd_pkg::S_CLQ;
      itd_pkg::S_CLQ: begin
        if ((up_p_r != anc_q) && at_top) begin
          state_nxt = itd_pkg::S_CLB;
        end else begin
          state_nxt = lvl_zero ? itd_pkg::S_FIN0 : itd_pkg::S_CLB;
        end
      end
      itd_pkg::S_FIN0:   state_nxt = itd_pkg::S_FIN1;
      itd_pkg::S_FIN1:   state_nxt = itd_pkg::S_MDEP;
      itd_pkg::S_MDEP: begin
        state_nxt = (path_len > diam_r || pass_r) ? itd_pkg::S_SWAP : itd_pkg::S_LSTART;
      end
      itd_pkg::S_SWAP:   state_nxt = itd_pkg::S_DONE;
      itd_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = itd_pkg::S_IDLE;
        end
      end
      default:           state_nxt = itd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    anc_req  = '0;
    dep_req  = '0;
    in_ready = 1'b0;
    unique case (state_r)
      itd_pkg::S_IDLE: begin
        in_ready        = 1'b1;
        dep_req.rd      = 1'b1;
        dep_req.rd_node = in_attach_node;
      end
      itd_pkg::S_XDEP: begin
        dep_req.wr      = 1'b1;
        dep_req.wr_node = n1;
        dep_req.wr_data = dep_q + itd_pkg::DEP_W'(1);
      end
      itd_pkg::S_WDEP2: begin
        dep_req.wr      = 1'b1;
        dep_req.wr_node = n2;
        dep_req.wr_data = d_r;
        anc_req.wr      = 1'b1;
        anc_req.wr_node = n1;
        anc_req.wr_data = x_r;
      end
      itd_pkg::S_W0B: begin
        anc_req.wr      = 1'b1;
        anc_req.wr_node = n2;
        anc_req.wr_data = x_r;
      end
      itd_pkg::S_FSEL: begin
        anc_req.rd      = fill_go;
        anc_req.rd_node = n1;
        anc_req.rd_lvl  = lvl_r - itd_pkg::LVL_W'(1);
      end
      itd_pkg::S_FRD1: begin
        anc_req.rd      = 1'b1;
        anc_req.rd_node = anc_q;
        anc_req.rd_lvl  = lvl_r - itd_pkg::LVL_W'(1);
      end
      itd_pkg::S_FWA: begin
        anc_req.wr      = 1'b1;
        anc_req.wr_node = n1;
        anc_req.wr_lvl  = lvl_r;
        anc_req.wr_data = a_r;
      end
      itd_pkg::S_FWB: begin
        anc_req.wr      = 1'b1;
        anc_req.wr_node = n2;
        anc_req.wr_lvl  = lvl_r;
        anc_req.wr_data = a_r;
      end
      itd_pkg::S_LIFT: begin
        anc_req.rd      = lift_go;
        anc_req.rd_node = q_r;
        anc_req.rd_lvl  = lvl_r;
      end
      itd_pkg::S_EQ: begin
        dep_req.rd      = (p_r == q_r);
        dep_req.rd_node = p_r;
      end
      itd_pkg::S_CLB: begin
        anc_req.rd      = climb_go;
        anc_req.rd_node = p_r;
        anc_req.rd_lvl  = lvl_r;
      end
      itd_pkg::S_CLP: begin
        anc_req.rd      = 1'b1;
        anc_req.rd_node = q_r;
        anc_req.rd_lvl  = lvl_r;
      end
      itd_pkg::S_FIN0: begin
        anc_req.rd      = 1'b1;
        anc_req.rd_node = p_r;
      end
      itd_pkg::S_FIN1: begin
        dep_req.rd      = 1'b1;
        dep_req.rd_node = anc_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itd_pkg::S_IDLE;
      end_a_r     <= itd_pkg::RESET_A;
      end_b_r     <= itd_pkg::RESET_B;
      dep_a_r     <= itd_pkg::DEP_W'(1);
      dep_b_r     <= itd_pkg::DEP_W'(1);
      diam_r      <= itd_pkg::DIST_W'(2);
      cnt_r       <= itd_pkg::RESET_CNT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && state_r != itd_pkg::S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        itd_pkg::S_IDLE: begin
          x_r      <= in_attach_node;
          lvl_r    <= '0;
          pass_r   <= 1'b0;
          status_r <= absent ? itd_pkg::ST_ABSENT :
                      (full ? itd_pkg::ST_FULL : itd_pkg::ST_OK);
        end
        itd_pkg::S_XDEP:  d_r   <= dep_q + itd_pkg::DEP_W'(1);
        itd_pkg::S_W0B:   lvl_r <= itd_pkg::LVL_W'(1);
        itd_pkg::S_FSEL: begin
          if (!fill_go) begin
            a_r <= itd_pkg::ROOT_NODE;
          end
        end
        itd_pkg::S_FRD2:  a_r <= anc_q;
        itd_pkg::S_FWB: begin
          if (!at_top) begin
            lvl_r <= lvl_r + itd_pkg::LVL_W'(1);
          end
        end
        itd_pkg::S_LSTART: begin
          de_r  <= de_sel;
          lvl_r <= itd_pkg::LVL_TOP;
          if (de_sel > d_r) begin
            p_r    <= n1;
            q_r    <= e_sel;
            diff_r <= de_sel - d_r;
            dcur_r <= d_r;
          end else begin
            p_r    <= e_sel;
            q_r    <= n1;
            diff_r <= d_r - de_sel;
            dcur_r <= de_sel;
          end
        end
        itd_pkg::S_LIFT: begin
          if (!lift_go && !lvl_zero) begin
            lvl_r <= lvl_r - itd_pkg::LVL_W'(1);
          end
        end
        itd_pkg::S_LIFTW: begin
          q_r    <= anc_q;
          diff_r <= diff_r - itd_pkg::DEP_W'(step);
        end
        itd_pkg::S_EQ:    lvl_r <= itd_pkg::LVL_TOP;
        itd_pkg::S_CLB: begin
          if (!climb_go && !lvl_zero) begin
            lvl_r <= lvl_r - itd_pkg::LVL_W'(1);
          end
        end
        itd_pkg::S_CLP:   up_p_r <= anc_q;
        itd_pkg::S_CLQ: begin
          if (up_p_r != anc_q) begin
            p_r    <= up_p_r;
            q_r    <= anc_q;
            dcur_r <= dcur_r - itd_pkg::DEP_W'(step);
          end
          if (!((up_p_r != anc_q) && at_top) && !lvl_zero) begin
            lvl_r <= lvl_r - itd_pkg::LVL_W'(1);
          end
        end
        itd_pkg::S_MDEP: begin
          pass_r <= 1'b1;
          if (path_len > diam_r) begin
            diam_r <= path_len;
            if (pass_r) begin
              end_a_r <= n1;
              dep_a_r <= d_r;
            end else begin
              end_b_r <= n1;
              dep_b_r <= d_r;
            end
          end
        end
        itd_pkg::S_SWAP: begin
          cnt_r <= n2;
          if (dep_a_r < dep_b_r) begin
            end_a_r <= end_b_r;
            end_b_r <= end_a_r;
            dep_a_r <= dep_b_r;
            dep_b_r <= dep_a_r;
          end
        end
        itd_pkg::S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_status_r   <= status_r;
            out_diameter_r <= (diam_ext > (itd_pkg::DIST_W + itd_pkg::DIAM_W)'(16'hFFFF)) ?
                              '1 : diam_ext[itd_pkg::DIAM_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_diameter = out_diameter_r;
  assign out_status   = out_status_r;

endmodule
`default_nettype wire

// File: src/incremental_tree_diameter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// incremental_tree_diameter_top
// Growing rooted tree with binary-lifting ancestors; reports the diameter
// after each pair of leaves is attached.
//
//   Channel  Dir  Payload                    Handshake
//   in_ch    in   attach_node[16:0]          valid/ready
//   out_ch   out  diameter[15:0], status[1:0] valid/ready
//
// One item is processed at a time. An accepted item writes the leaves,
// fills the new ancestor rows level by level, then runs one or two LCA
// walks, every step a read of the single ancestor memory read port.
// Absent or full items skip all of this and go straight to the result.
// Reset is synchronous and needs no clearing pass; the fixed starting nodes
// are answered from logic. A held result stalls the next item only at its
// final step.
// ----------------------------------------------------------------------------
module incremental_tree_diameter_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  itd_in_if.sink     in_ch,
  itd_out_if.source  out_ch
);

  itd_pkg::anc_req_t          anc_req;
  itd_pkg::dep_req_t          dep_req;
  logic [itd_pkg::NODE_W-1:0] anc_q;
  logic [itd_pkg::DEP_W-1:0]  dep_q;

  itd_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_attach_node (in_ch.attach_node),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_diameter   (out_ch.diameter),
    .out_status     (out_ch.status),
    .anc_req        (anc_req),
    .dep_req        (dep_req),
    .anc_q          (anc_q),
    .dep_q          (dep_q)
  );

  itd_store u_store (
    .clk     (clk),
    .anc_req (anc_req),
    .dep_req (dep_req),
    .anc_q   (anc_q),
    .dep_q   (dep_q)
  );

endmodule
`default_nettype wire

// File: src/itd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itd_checker
// Port-level checks: held results stay stable, the diameter never shrinks
// or grows by more than one, and a rejected item reports the previous diameter.
// ----------------------------------------------------------------------------
module itd_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [itd_pkg::DIAM_W-1:0] out_diameter,
  input wire logic [itd_pkg::ST_W-1:0]   out_status
);

  logic [itd_pkg::DIAM_W-1:0] last_diam_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_diam_r <= itd_pkg::DIAM_W'(2);
    end else if (out_valid && out_ready) begin
      last_diam_r <= out_diameter;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_diameter) && $stable(out_status))
    else $error("result changed while stalled");

  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_diameter >= last_diam_r)
    else $error("diameter decreased");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != itd_pkg::ST_OK |-> out_diameter == last_diam_r)
    else $error("rejected item changed the diameter");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == itd_pkg::ST_OK |-> out_diameter <= last_diam_r + 16'd1)
    else $error("diameter grew by more than one");

endmodule

bind incremental_tree_diameter_top itd_checker u_itd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_diameter (out_ch.diameter),
  .out_status   (out_ch.status)
);
`default_nettype wire

// File: tb/incremental_tree_diameter_top_tb.sv
// ----------------------------------------------------------------------------
// incremental_tree_diameter_top_tb
// Drives attach requests into the tree diameter block and checks every
// result item against a local model of the tree. The model keeps depths and
// parent links and finds distances by walking up from both nodes.
// ----------------------------------------------------------------------------
module incremental_tree_diameter_top_tb;

  logic clk;
  logic rst_n;

  itd_in_if  in_ch();
  itd_out_if out_ch();

  incremental_tree_diameter_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  typedef struct {
    logic [itd_pkg::DIAM_W-1:0] diameter;
    itd_pkg::status_t           status;
  } diam_res_t;

  int unsigned       tree_depth [int unsigned];
  int unsigned       tree_parent [int unsigned];
  int unsigned       end_a;
  int unsigned       end_b;
  int unsigned       diam_now;
  int unsigned       node_total;
  diam_res_t         diam_expected [$];
  int                error_count;
  bit                recv_hold;
  int unsigned       hold_cycles;
  int unsigned       items_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned tree_dist(input int unsigned p, input int unsigned q);
    int unsigned dp;
    int unsigned dq;
    int unsigned n;
    n = 0;
    dp = tree_depth[p];
    dq = tree_depth[q];
    while (dp > dq) begin
      p = tree_parent[p];
      dp--;
      n++;
    end
    while (dq > dp) begin
      q = tree_parent[q];
      dq--;
      n++;
    end
    while (p != q) begin
      p = tree_parent[p];
      q = tree_parent[q];
      n += 2;
    end
    return n;
  endfunction

  function automatic void tree_reset();
    tree_depth.delete();
    tree_parent.delete();
    tree_depth[1] = 0;
    for (int unsigned k = 2; k <= 4; k++) begin
      tree_depth[k]  = 1;
      tree_parent[k] = 1;
    end
    end_a = 2;
    end_b = 3;
    diam_now = 2;
    node_total = 4;
  endfunction

  function automatic diam_res_t predict_attach(input int unsigned x);
    diam_res_t r;
    int unsigned n1;
    int unsigned cur;
    int unsigned t;
    if (x == 0 || x > node_total) begin
      r.status = itd_pkg::ST_ABSENT;
    end else if (node_total + 2 > itd_pkg::MAX_NODES) begin
      r.status = itd_pkg::ST_FULL;
    end else begin
      r.status = itd_pkg::ST_OK;
      n1 = node_total + 1;
      for (int unsigned k = n1; k <= n1 + 1; k++) begin
        tree_depth[k]  = tree_depth[x] + 1;
        tree_parent[k] = x;
      end
      cur = tree_dist(end_a, end_b);
      if (tree_dist(end_a, n1) > cur) begin
        end_b = n1;
        cur = tree_dist(end_a, end_b);
      end else if (tree_dist(end_b, n1) > cur) begin
        end_a = n1;
        cur = tree_dist(end_b, end_a);
      end
      if (tree_depth[end_a] < tree_depth[end_b]) begin
        t = end_a;
        end_a = end_b;
        end_b = t;
      end
      diam_now = cur;
      node_total += 2;
    end
    r.diameter = (diam_now > 65535) ? 16'hFFFF : itd_pkg::DIAM_W'(diam_now);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic send_attach(input int unsigned x, input bit no_gap = 0);
    int gap;
    diam_res_t r;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.attach_node <= itd_pkg::NODE_W'(x);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = predict_attach(x);
    diam_expected = {diam_expected, r};
  endtask

  always @(posedge clk) begin
    diam_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (diam_expected.size() == 0) begin
        report_mismatch("result item with none expected");
      end else begin
        e = diam_expected.pop_front();
        if (out_ch.status !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, e.status));
        if (out_ch.diameter !== e.diameter)
          report_mismatch($sformatf("diameter %0d, expected %0d",
                                    out_ch.diameter, e.diameter));
      end
    end
  end

  always @(posedge clk) begin
    int unsigned w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      items_left   <= 0;
    end else if (recv_hold || hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end else if (items_left > 0) begin
      out_ch.ready <= 1'b0;
      items_left   <= items_left - 1;
    end else if (out_ch.valid && out_ch.ready) begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (w == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        items_left   <= w - 1;
      end
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (diam_expected.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_node();
    case ($urandom_range(0, 3))
      0: return node_total - $urandom_range(0, (node_total > 6) ? 5 : 0);
      1: return $urandom_range(1, 4);
      default: return $urandom_range(1, node_total);
    endcase
  endfunction

  task automatic test_directed();
    send_attach(0);
    send_attach(1);
    send_attach(node_total);
    send_attach(node_total + 1);
    send_attach(17'h1FFFF);
    send_attach(17'h10000);
    send_attach(2);
    send_attach(3);
    send_attach(4);
    for (int k = 0; k < 10; k++) send_attach(node_total);
    send_attach(1);
    send_attach(node_total - 1);
    wait_drained();
  endtask

  task automatic test_deep_chain();
    for (int k = 0; k < 150; k++) begin
      send_attach(($urandom_range(0, 4) == 0) ? pick_node() : node_total, 1);
    end
  endtask

  task automatic test_random(input int n);
    int unsigned x;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) x = $urandom_range(0, 17'h1FFFF);
      else x = pick_node();
      send_attach(x, $urandom_range(0, 4) == 0);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles <= 3000;
    for (int k = 0; k < 20; k++) send_attach(pick_node(), 1);
    wait_drained();
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.attach_node <= '0;
    rst_n             <= 1'b0;
    recv_hold          = 1'b0;
    hold_cycles        = 0;
    error_count        = 0;
    tree_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_deep_chain();
    test_random(950);
    wait_drained();
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/itd_pkg.sv
src/itd_if.sv
src/itd_store.sv
src/itd_ctrl.sv
src/incremental_tree_diameter_top.sv
src/itd_checker.sv
tb/incremental_tree_diameter_top_tb.sv
